// File: rtl/rcdq_pkg.sv
// Shared types and constants for the restricted circular deque unit.
// Depends on nothing; imported by the cell and the top level.
package rcdq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int WORD_W    = 32;
    localparam int OCC_W     = 4;

    typedef enum logic [1:0] {
        OP_INS_RIGHT = 2'd0,
        OP_INS_LEFT  = 2'd1,
        OP_DEL_LEFT  = 2'd2,
        OP_DEL_RIGHT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_FORBIDDEN = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INS_RIGHT,
        CMD_INS_LEFT,
        CMD_DEL_LEFT,
        CMD_DEL_RIGHT
    } cmd_t;

    typedef struct packed {
        cmd_t                      cmd;
        logic signed [WORD_W-1:0]  word;
    } cell_ctl_t;

endpackage

// File: rtl/rcdq_cell.sv
// One storage cell of the deque chain: a word and an occupied bit.
// Depends on rcdq_pkg; instantiated in a row by restricted_circular_deque_unit.
module rcdq_cell
    import rcdq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctl_t                ctl,
    input  logic signed [WORD_W-1:0] left_data,
    input  logic                     left_occ,
    input  logic signed [WORD_W-1:0] right_data,
    input  logic                     right_occ,
    output logic signed [WORD_W-1:0] data,
    output logic                     occ,
    output logic signed [WORD_W-1:0] tail_word
);

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;
    logic                     occ_reg;
    logic                     occ_next;

    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        unique case (ctl.cmd)
            CMD_HOLD:
            begin
            end
            CMD_INS_LEFT:
            begin
                data_next = left_data;
                occ_next  = left_occ;
            end
            CMD_DEL_LEFT:
            begin
                data_next = right_data;
                occ_next  = right_occ;
            end
            CMD_INS_RIGHT:
            begin
                if (!occ_reg && left_occ)
                begin
                    data_next = ctl.word;
                    occ_next  = 1'b1;
                end
            end
            CMD_DEL_RIGHT:
            begin
                if (occ_reg && !right_occ)
                begin
                    occ_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign occ       = occ_reg;
    assign tail_word = (occ_reg && !right_occ) ? data_reg : '0;

endmodule

// File: rtl/restricted_circular_deque_unit.sv
// Top level of the restricted deque: control, mode register, result register.
// Depends on rcdq_pkg and rcdq_cell.
//
//  channel   | handshake           | payload
//  ----------+---------------------+--------------------------------------
//  input     | in_valid / in_ready | op, value
//  result    | out_valid/out_ready | status, removed_value, occupancy
//  config    | cfg_we              | cfg_data (restriction mode)
//
// The cell row is updated as the result is registered, and a new transaction
// is taken whenever the result register is empty or being emptied, so one
// transaction per cycle is sustained.
// Reset empties the row at once by clearing each cell's occupied bit.
// A stalled result holds the input channel off until it is taken.
module restricted_circular_deque_unit
    import rcdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               op,
    input  logic signed [WORD_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic signed [WORD_W-1:0] removed_value,
    output logic [OCC_W-1:0]         occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                     mode_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     out_valid_reg;
    status_t                  status_reg;
    status_t                  status_next;
    logic signed [WORD_W-1:0] removed_reg;
    logic signed [WORD_W-1:0] removed_next;
    logic [OCC_W-1:0]         occ_reg;
    logic [CW+OCC_W-1:0]      count_ext;

    logic                     in_fire;
    logic                     forbidden;
    logic                     full;
    logic                     empty;
    op_t                      op_code;
    cell_ctl_t                ctl;

    logic signed [WORD_W-1:0] data_w [DEPTH];
    logic signed [WORD_W-1:0] tail_w [DEPTH];
    logic [DEPTH-1:0]         occ_vec;
    logic signed [WORD_W-1:0] tail_word;

    assign op_code   = op_t'(op);
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign forbidden = (!mode_reg && op_code == OP_INS_LEFT) ||
                       (mode_reg && op_code == OP_DEL_RIGHT);

    always_comb
    begin
        tail_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_word = tail_word | tail_w[i];
        end
    end

    always_comb
    begin
        status_next  = ST_DONE;
        removed_next = '0;
        count_next   = count_reg;
        ctl.cmd      = CMD_HOLD;
        ctl.word     = value;
        if (forbidden)
        begin
            status_next = ST_FORBIDDEN;
        end
        else
        begin
            unique case (op_code)
                OP_INS_RIGHT, OP_INS_LEFT:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        ctl.cmd    = (op_code == OP_INS_RIGHT) ? CMD_INS_RIGHT
                                                               : CMD_INS_LEFT;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_DEL_LEFT, OP_DEL_RIGHT:
                begin
                    if (empty)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        ctl.cmd      = (op_code == OP_DEL_LEFT) ? CMD_DEL_LEFT
                                                                : CMD_DEL_RIGHT;
                        removed_next = (op_code == OP_DEL_LEFT) ? data_w[0]
                                                                : tail_word;
                        count_next   = count_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (!in_fire)
        begin
            ctl.cmd    = CMD_HOLD;
            count_next = count_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic signed [WORD_W-1:0] l_data;
            logic                     l_occ;
            logic signed [WORD_W-1:0] r_data;
            logic                     r_occ;
            if (g == 0)
            begin : g_first
                assign l_data = value;
                assign l_occ  = 1'b1;
            end
            else
            begin : g_mid_l
                assign l_data = data_w[g-1];
                assign l_occ  = occ_vec[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign r_data = '0;
                assign r_occ  = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_data = data_w[g+1];
                assign r_occ  = occ_vec[g+1];
            end
            rcdq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .left_data  (l_data),
                .left_occ   (l_occ),
                .right_data (r_data),
                .right_occ  (r_occ),
                .data       (data_w[g]),
                .occ        (occ_vec[g]),
                .tail_word  (tail_w[g])
            );
        end
    endgenerate

    assign count_ext = (CW + OCC_W)'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            count_reg <= count_next;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            occ_reg     <= count_ext[OCC_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign occupancy     = occ_reg;

    // The occupied cells always form one run starting at the left end.
    a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_vec & ~{occ_vec[DEPTH-2:0], 1'b1}) == '0)
        else $error("occupied cells are not packed to the left");

    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        CW'($countones(occ_vec)) == count_reg)
        else $error("fill count disagrees with occupied cells");

    a_forbidden_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && forbidden) |=> $stable(count_reg) && $stable(occ_vec))
        else $error("forbidden transaction changed the store");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_OVERFLOW) |-> full)
        else $error("overflow reported while not full");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_UNDERFLOW) |-> empty)
        else $error("underflow reported while not empty");

endmodule
